/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the extractor modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset
`define JSFX_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every clock edge, reset included
`define JSFX_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

/* hw/rtl/jsfx_pkg.sv */
// Types, constants and helpers of the JSON string field extractor
package jsfx_pkg;

  localparam int unsigned KEY_MAX_DEF     = 16;
  localparam int unsigned LENGTH_BITS_DEF = 16;
  localparam int unsigned CNT_W           = 16;
  localparam int unsigned FIFO_DEPTH      = 8;
  localparam int unsigned RES_MAX         = 4;
  localparam int unsigned KEY_BYTES       = 16;

  localparam logic [15:0] CAP_RST = 16'd32768;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_U     = 8'h75;

  localparam logic [1:0] REG_KEY_LO  = 2'd0;
  localparam logic [1:0] REG_KEY_HI  = 2'd1;
  localparam logic [1:0] REG_KEY_LEN = 2'd2;
  localparam logic [1:0] REG_CAP     = 2'd3;

  typedef enum logic [2:0] {
    PH_SEARCH,
    PH_COLON,
    PH_QUOTE,
    PH_VALUE,
    PH_ESCAPE,
    PH_HEX,
    PH_DONE
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK,
    ST_ABSENT,
    ST_NOCOLON,
    ST_LONG,
    ST_BADESC,
    ST_UNTERM,
    ST_SURR
  } status_e;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             final_res;
    status_e          status;
    logic [CNT_W-1:0] length;
  } result_t;

  typedef struct packed {
    logic [2:0]                cnt;
    result_t [RES_MAX-1:0]     data;
  } push_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  function automatic logic [7:0] key_byte(logic [8*KEY_BYTES-1:0] key, logic [5:0] idx);
    logic [7:0] res;
    res = 8'h00;
    if (idx < 6'(KEY_BYTES)) begin
      res = key[{idx[3:0], 3'b000} +: 8];
    end
    return res;
  endfunction

endpackage

/* hw/rtl/jsfx_if.sv */
// Request and result channel interfaces of the extractor
interface jsfx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       line_end;

  modport source (output valid, in_byte, line_end, input ready);
  modport sink   (input valid, in_byte, line_end, output ready);
endinterface

interface jsfx_out_if #(
  parameter int unsigned LENGTH_BITS = jsfx_pkg::LENGTH_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [7:0]             out_byte;
  logic                   final_res;
  logic [2:0]             status;
  logic [LENGTH_BITS-1:0] length;

  modport source (output valid, out_byte, final_res, status, length, input ready);
  modport sink   (input valid, out_byte, final_res, status, length, output ready);
endinterface

/* hw/rtl/json_string_field_extractor_core.sv */
// Results: each accepted request's results are registered in the result queue and offered on rsp_o in order.
// Throughput: one request per cycle; ready drops while fewer than four result slots are free,
// so a request that expands to several UTF-8 bytes holds intake until the queue drains.
// Key match: a chain of KEY_MAX+2 window cells compares in the same cycle as the shift.
// Reset: asynchronous, clears phase, window, counters and queue; registers take reset values.
`include "assert_macros.svh"
module json_string_field_extractor_core #(
  parameter int unsigned KEY_MAX     = jsfx_pkg::KEY_MAX_DEF,
  parameter int unsigned LENGTH_BITS = jsfx_pkg::LENGTH_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  jsfx_in_if.sink      req_i,
  jsfx_out_if.source   rsp_o,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [63:0]  cfg_data_i
);
  import jsfx_pkg::*;

  logic [63:0]       key_lo_q, key_hi_q;
  logic [4:0]        key_len_q;
  logic [15:0]       cap_q;

  phase_e            phase_q, phase_d, phase_take;
  logic [15:0]       hex_q, hex_d;
  logic [1:0]        dig_q, dig_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  logic              acc, space, match;
  logic [7:0]        b;
  logic              last;
  cell_ctl_t         win_ctl;

  logic              is_blank, hex_ok, esc_ok, cap_hit, surr;
  logic [3:0]        hex_dig;
  logic [7:0]        esc_chr;
  logic [15:0]       hex_next;

  logic [1:0]        nb;
  logic [7:0]        ob [3];
  logic              fin_take, fin;
  status_e           st_take, fin_st;
  push_t             push;
  result_t           head;

  assign acc         = req_i.valid && req_i.ready;
  assign req_i.ready = space;
  assign b           = req_i.in_byte;
  assign last        = req_i.line_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_lo_q  <= '0;
      key_hi_q  <= '0;
      key_len_q <= '0;
      cap_q     <= CAP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_KEY_LO:  key_lo_q  <= cfg_data_i;
        REG_KEY_HI:  key_hi_q  <= cfg_data_i;
        REG_KEY_LEN: key_len_q <= cfg_data_i[4:0];
        REG_CAP:     cap_q     <= cfg_data_i[15:0];
        default:     ;
      endcase
    end
  end

  assign win_ctl.shift = acc && (phase_q == PH_SEARCH) && (b != CH_NUL);
  assign win_ctl.clear = acc && last;

  jsfx_window #(.KEY_MAX(KEY_MAX)) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (win_ctl),
    .byte_i    (b),
    .key_i     ({key_hi_q, key_lo_q}),
    .key_len_i (key_len_q),
    .match_o   (match)
  );

  always_comb begin
    is_blank = (b == CH_SPACE) || (b == CH_TAB);
    cap_hit  = ({1'b0, cnt_q} + 17'd4) >= {1'b0, cap_q};
    hex_ok   = 1'b1;
    hex_dig  = 4'h0;
    if (b >= 8'h30 && b <= 8'h39) begin
      hex_dig = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      hex_dig = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      hex_dig = 4'(b - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
    hex_next = {hex_q[11:0], hex_dig};
    surr     = (hex_next[15:11] == 5'b11011);
    esc_ok   = 1'b1;
    case (b)
      CH_QUOTE: esc_chr = CH_QUOTE;
      CH_BSL:   esc_chr = CH_BSL;
      CH_SLASH: esc_chr = CH_SLASH;
      8'h62:    esc_chr = 8'h08;
      8'h66:    esc_chr = 8'h0C;
      8'h6E:    esc_chr = 8'h0A;
      8'h72:    esc_chr = 8'h0D;
      8'h74:    esc_chr = 8'h09;
      default: begin
        esc_chr = 8'h00;
        esc_ok  = 1'b0;
      end
    endcase
  end

  // next phase
  always_comb begin
    phase_take = phase_q;
    unique case (phase_q)
      PH_SEARCH: begin
        if (b == CH_NUL) begin
          phase_take = PH_DONE;
        end else if (match) begin
          phase_take = PH_COLON;
        end
      end
      PH_COLON: begin
        if (!is_blank) begin
          phase_take = (b == CH_COLON) ? PH_QUOTE : PH_DONE;
        end
      end
      PH_QUOTE: begin
        if (!is_blank) begin
          phase_take = (b == CH_QUOTE) ? PH_VALUE : PH_DONE;
        end
      end
      PH_VALUE: begin
        if (b == CH_QUOTE || b == CH_NUL || cap_hit) begin
          phase_take = PH_DONE;
        end else if (b == CH_BSL) begin
          phase_take = PH_ESCAPE;
        end
      end
      PH_ESCAPE: begin
        if (b == CH_U) begin
          phase_take = PH_HEX;
        end else if (esc_ok) begin
          phase_take = PH_VALUE;
        end else begin
          phase_take = PH_DONE;
        end
      end
      PH_HEX: begin
        if (!hex_ok) begin
          phase_take = PH_DONE;
        end else if (dig_q == 2'd3) begin
          phase_take = surr ? PH_DONE : PH_VALUE;
        end
      end
      PH_DONE: phase_take = PH_DONE;
      default: phase_take = PH_SEARCH;
    endcase
    phase_d = phase_q;
    if (acc) begin
      phase_d = last ? PH_SEARCH : phase_take;
    end
  end

  // results and datapath
  always_comb begin
    nb      = 2'd0;
    ob[0]   = 8'h00;
    ob[1]   = 8'h00;
    ob[2]   = 8'h00;
    st_take = ST_ABSENT;
    hex_d   = hex_q;
    dig_d   = dig_q;
    cnt_d   = cnt_q;
    case (phase_q)
      PH_SEARCH: st_take = ST_ABSENT;
      PH_COLON:  st_take = ST_NOCOLON;
      PH_QUOTE: begin
        st_take = ST_NOCOLON;
        if (b == CH_QUOTE) begin
          cnt_d = '0;
        end
      end
      PH_VALUE: begin
        if (b == CH_QUOTE) begin
          st_take = ST_OK;
        end else if (b == CH_NUL) begin
          st_take = ST_UNTERM;
        end else begin
          st_take = ST_LONG;
          if (!cap_hit && b != CH_BSL) begin
            nb    = 2'd1;
            ob[0] = b;
            cnt_d = cnt_q + CNT_W'(1);
          end
        end
      end
      PH_ESCAPE: begin
        st_take = (b == CH_NUL) ? ST_UNTERM : ST_BADESC;
        if (b == CH_U) begin
          hex_d = '0;
          dig_d = '0;
        end else if (esc_ok) begin
          nb    = 2'd1;
          ob[0] = esc_chr;
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      PH_HEX: begin
        st_take = (b == CH_NUL) ? ST_UNTERM : ST_BADESC;
        if (hex_ok) begin
          hex_d = hex_next;
          if (dig_q == 2'd3) begin
            dig_d   = '0;
            st_take = ST_SURR;
            if (!surr) begin
              if (hex_next < 16'h0080) begin
                nb    = 2'd1;
                ob[0] = hex_next[7:0];
                cnt_d = cnt_q + CNT_W'(1);
              end else if (hex_next < 16'h0800) begin
                nb    = 2'd2;
                ob[0] = {3'b110, hex_next[10:6]};
                ob[1] = {2'b10, hex_next[5:0]};
                cnt_d = cnt_q + CNT_W'(2);
              end else begin
                nb    = 2'd3;
                ob[0] = {4'b1110, hex_next[15:12]};
                ob[1] = {2'b10, hex_next[11:6]};
                ob[2] = {2'b10, hex_next[5:0]};
                cnt_d = cnt_q + CNT_W'(3);
              end
            end
          end else begin
            dig_d = dig_q + 2'd1;
          end
        end
      end
      default: st_take = ST_ABSENT;
    endcase

    fin_take = (phase_take == PH_DONE) && (phase_q != PH_DONE);
    fin      = fin_take;
    fin_st   = st_take;
    if (!fin_take && last && phase_take != PH_DONE) begin
      fin = 1'b1;
      case (phase_take)
        PH_SEARCH:          fin_st = ST_ABSENT;
        PH_COLON, PH_QUOTE: fin_st = ST_NOCOLON;
        default:            fin_st = ST_UNTERM;
      endcase
    end

    if (acc && last) begin
      hex_d = '0;
      dig_d = '0;
      cnt_d = '0;
    end
    if (!acc) begin
      hex_d = hex_q;
      dig_d = dig_q;
      cnt_d = cnt_q;
    end

    push.cnt = acc ? (3'(nb) + 3'(fin)) : 3'd0;
    for (int k = 0; k < RES_MAX; k++) begin
      push.data[k].out_byte  = 8'h00;
      push.data[k].final_res = 1'b0;
      push.data[k].status    = ST_OK;
      push.data[k].length    = '0;
      if (k < 3 && 2'(k) < nb) begin
        push.data[k].out_byte = ob[k % 3];
      end else if (3'(k) == 3'(nb)) begin
        push.data[k].final_res = 1'b1;
        push.data[k].status    = fin_st;
        push.data[k].length    = (fin_st == ST_OK) ? cnt_q : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEARCH;
      hex_q   <= '0;
      dig_q   <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      hex_q   <= hex_d;
      dig_q   <= dig_d;
      cnt_q   <= cnt_d;
    end
  end

  jsfx_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .space_o    (space),
    .rd_valid_o (rsp_o.valid),
    .rd_ready_i (rsp_o.ready),
    .rd_data_o  (head)
  );

  assign rsp_o.out_byte  = head.out_byte;
  assign rsp_o.final_res = head.final_res;
  assign rsp_o.status    = head.status;
  assign rsp_o.length    = LENGTH_BITS'(head.length);

  `JSFX_ASSERT(a_line_end_search, ((acc && last) |=> ((phase_q == PH_SEARCH) && (cnt_q == '0))), "line end did not return to search")
  `JSFX_ASSERT(a_done_silent, ((acc && (phase_q == PH_DONE)) |-> (push.cnt == 3'd0)), "result after line final")

endmodule

/* hw/rtl/jsfx_cell.sv */
// One window cell: holds a line byte, compares the incoming byte to its pattern byte
module jsfx_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  jsfx_pkg::cell_ctl_t   ctl_i,
  input  logic [7:0]            byte_i,
  input  logic                  valid_i,
  input  logic [7:0]            want_i,
  input  logic                  used_i,
  output logic [7:0]            byte_o,
  output logic                  valid_o,
  output logic                  hit_o
);
  import jsfx_pkg::*;

  logic [7:0] byte_q;
  logic       valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.clear) begin
      valid_q <= 1'b0;
    end else if (ctl_i.shift) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o  = byte_q;
  assign valid_o = valid_q;
  assign hit_o   = !used_i || (valid_i && (byte_i == want_i));

endmodule

/* hw/rtl/jsfx_window.sv */
// Row of cells that matches the quoted key against the most recent line bytes
module jsfx_window #(
  parameter int unsigned KEY_MAX = jsfx_pkg::KEY_MAX_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  jsfx_pkg::cell_ctl_t                 ctl_i,
  input  logic [7:0]                          byte_i,
  input  logic [8*jsfx_pkg::KEY_BYTES-1:0]    key_i,
  input  logic [4:0]                          key_len_i,
  output logic                                match_o
);
  import jsfx_pkg::*;

  localparam int unsigned WIN = KEY_MAX + 2;
  localparam int unsigned CW  = $clog2(KEY_MAX + 3);

  logic [CW-1:0] klen;
  logic [CW:0]   last_pos;
  logic [7:0]    cell_byte [WIN];
  logic          cell_valid[WIN];
  logic [WIN-1:0] hit;

  always_comb begin
    klen = ({2'b00, key_len_i} > 7'(KEY_MAX)) ? CW'(KEY_MAX) : CW'(key_len_i);
  end

  assign last_pos = {1'b0, klen} + (CW+1)'(1);

  for (genvar d = 0; d < WIN; d++) begin : g_cell
    logic [7:0] up_byte;
    logic       up_valid;
    logic [7:0] want;
    logic       used;

    if (d == 0) begin : g_head
      assign up_byte  = byte_i;
      assign up_valid = 1'b1;
      assign want     = CH_QUOTE;
    end else begin : g_body
      assign up_byte  = cell_byte[d-1];
      assign up_valid = cell_valid[d-1];
      assign want     = ((CW+1)'(d) == last_pos) ? CH_QUOTE
                      : key_byte(key_i, 6'(klen - CW'(d)));
    end

    assign used = ((CW+1)'(d) <= last_pos);

    jsfx_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl_i),
      .byte_i  (up_byte),
      .valid_i (up_valid),
      .want_i  (want),
      .used_i  (used),
      .byte_o  (cell_byte[d]),
      .valid_o (cell_valid[d]),
      .hit_o   (hit[d])
    );
  end

  assign match_o = &hit;

endmodule

/* hw/rtl/jsfx_fifo.sv */
// Result queue: takes up to four results a cycle, hands out one
`include "assert_macros.svh"
module jsfx_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  jsfx_pkg::push_t     push_i,
  output logic                space_o,
  output logic                rd_valid_o,
  input  logic                rd_ready_i,
  output jsfx_pkg::result_t   rd_data_o
);
  import jsfx_pkg::*;

  localparam int unsigned PW = $clog2(FIFO_DEPTH);

  result_t      mem [FIFO_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PW:0]   count_q, count_d;
  logic          pop;

  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = mem[rd_ptr_q];
  assign space_o    = (count_q <= (PW+1)'(FIFO_DEPTH - RES_MAX));

  always_comb begin
    wr_ptr_d = wr_ptr_q + PW'(push_i.cnt);
    rd_ptr_d = rd_ptr_q + PW'(pop);
    count_d  = count_q + (PW+1)'(push_i.cnt) - (PW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < RES_MAX; k++) begin
      if (3'(k) < push_i.cnt) begin
        mem[wr_ptr_q + PW'(k)] <= push_i.data[k];
      end
    end
  end

  `JSFX_ASSERT_ALWAYS(a_count_bound, (count_q <= (PW+1)'(FIFO_DEPTH)), "result queue overflow")
  `JSFX_ASSERT(a_push_space, ((push_i.cnt != 3'd0) |-> space_o), "push without free slots")

endmodule

/* tb/sv/jsfx_tb_pkg.sv */
// Scoreboard that predicts and checks the extractor's decoded bytes and line status
package jsfx_tb_pkg;
  import jsfx_pkg::*;

  localparam int unsigned WIN_LEN = KEY_MAX_DEF + 2;

  localparam logic [7:0] CH_ESC_B = "b";
  localparam logic [7:0] CH_ESC_F = "f";
  localparam logic [7:0] CH_ESC_N = "n";
  localparam logic [7:0] CH_ESC_R = "r";
  localparam logic [7:0] CH_ESC_T = "t";
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [15:0] SURR_LO = 16'hD800;
  localparam logic [15:0] SURR_HI = 16'hDFFF;

  class field_scoreboard;
    logic [63:0] key_lo;
    logic [63:0] key_hi;
    logic [4:0]  key_len;
    logic [15:0] cap;
    phase_e      ph;
    logic [7:0]  win [WIN_LEN];
    int unsigned fill;
    logic [15:0] hex_acc;
    int unsigned hex_cnt;
    logic [15:0] written;
    result_t     decoded_q [$];
    int unsigned errors;

    function new();
      key_lo  = '0;
      key_hi  = '0;
      key_len = '0;
      cap     = CAP_RST;
      errors  = 0;
      clear_line();
    endfunction

    function void clear_line();
      ph = PH_SEARCH;
      foreach (win[i]) win[i] = '0;
      fill    = 0;
      hex_acc = '0;
      hex_cnt = 0;
      written = '0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [63:0] data);
      case (idx)
        REG_KEY_LO:  key_lo = data;
        REG_KEY_HI:  key_hi = data;
        REG_KEY_LEN: key_len = data[4:0];
        REG_CAP:     cap = data[15:0];
        default: ;
      endcase
    endfunction

    function void emit_byte(logic [7:0] b);
      result_t r;
      r.out_byte  = b;
      r.final_res = 1'b0;
      r.status    = ST_OK;
      r.length    = '0;
      decoded_q.push_back(r);
    endfunction

    function void emit_final(status_e st);
      result_t r;
      r.out_byte  = '0;
      r.final_res = 1'b1;
      r.status    = st;
      r.length    = (st == ST_OK) ? written : '0;
      decoded_q.push_back(r);
      ph = PH_DONE;
    endfunction

    function logic [7:0] key_char(int unsigned i);
      if (i < 8) return key_lo[8*i +: 8];
      if (i < 16) return key_hi[8*(i-8) +: 8];
      return 8'h00;
    endfunction

    function bit key_seen();
      int unsigned plen;
      logic [7:0] want;
      plen = ((key_len > KEY_MAX_DEF) ? KEY_MAX_DEF : int'(key_len)) + 2;
      if (fill < plen) return 1'b0;
      for (int unsigned j = 0; j < plen; j++) begin
        want = (j == 0 || j == plen - 1) ? CH_QUOTE : key_char(j - 1);
        if (win[WIN_LEN - plen + j] != want) return 1'b0;
      end
      return 1'b1;
    endfunction

    function bit is_blank(logic [7:0] b);
      return b == CH_SPACE || b == CH_TAB;
    endfunction

    function void finish_code();
      if (hex_acc >= SURR_LO && hex_acc <= SURR_HI) begin
        emit_final(ST_SURR);
        return;
      end
      if (hex_acc < 16'h0080) begin
        emit_byte(hex_acc[7:0]);
        written += 1;
      end else if (hex_acc < 16'h0800) begin
        emit_byte({3'b110, hex_acc[10:6]});
        emit_byte({2'b10, hex_acc[5:0]});
        written += 2;
      end else begin
        emit_byte({4'b1110, hex_acc[15:12]});
        emit_byte({2'b10, hex_acc[11:6]});
        emit_byte({2'b10, hex_acc[5:0]});
        written += 3;
      end
      ph = PH_VALUE;
    endfunction

    function void advance(logic [7:0] b);
      logic [7:0] c;
      bit simple;
      int unsigned d;
      case (ph)
        PH_SEARCH: begin
          if (b == CH_NUL) begin
            emit_final(ST_ABSENT);
          end else begin
            for (int i = 0; i < WIN_LEN - 1; i++) win[i] = win[i+1];
            win[WIN_LEN-1] = b;
            if (fill < WIN_LEN) fill++;
            if (key_seen()) ph = PH_COLON;
          end
        end
        PH_COLON: begin
          if (!is_blank(b)) begin
            if (b == CH_COLON) ph = PH_QUOTE;
            else emit_final(ST_NOCOLON);
          end
        end
        PH_QUOTE: begin
          if (!is_blank(b)) begin
            if (b == CH_QUOTE) begin
              written = '0;
              ph = PH_VALUE;
            end else begin
              emit_final(ST_NOCOLON);
            end
          end
        end
        PH_VALUE: begin
          if (b == CH_QUOTE) emit_final(ST_OK);
          else if (b == CH_NUL) emit_final(ST_UNTERM);
          else if (int'(written) + 4 >= int'(cap)) emit_final(ST_LONG);
          else if (b == CH_BSL) ph = PH_ESCAPE;
          else begin
            emit_byte(b);
            written++;
          end
        end
        PH_ESCAPE: begin
          simple = 1'b1;
          c = b;
          case (b)
            CH_QUOTE, CH_BSL, CH_SLASH: c = b;
            CH_ESC_B: c = CH_BS;
            CH_ESC_F: c = CH_FF;
            CH_ESC_N: c = CH_LF;
            CH_ESC_R: c = CH_CR;
            CH_ESC_T: c = CH_TAB;
            default: simple = 1'b0;
          endcase
          if (simple) begin
            emit_byte(c);
            written++;
            ph = PH_VALUE;
          end else if (b == CH_U) begin
            hex_acc = '0;
            hex_cnt = 0;
            ph = PH_HEX;
          end else if (b == CH_NUL) begin
            emit_final(ST_UNTERM);
          end else begin
            emit_final(ST_BADESC);
          end
        end
        PH_HEX: begin
          if (b >= "0" && b <= "9") d = b - "0";
          else if (b >= "a" && b <= "f") d = b - "a" + 10;
          else if (b >= "A" && b <= "F") d = b - "A" + 10;
          else d = 16;
          if (d == 16) begin
            if (b == CH_NUL) emit_final(ST_UNTERM);
            else emit_final(ST_BADESC);
          end else begin
            hex_acc = {hex_acc[11:0], d[3:0]};
            if (hex_cnt == 3) begin
              hex_cnt = 0;
              finish_code();
            end else begin
              hex_cnt++;
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void take_request(logic [7:0] b, logic last);
      advance(b);
      if (last) begin
        case (ph)
          PH_SEARCH:          emit_final(ST_ABSENT);
          PH_COLON, PH_QUOTE: emit_final(ST_NOCOLON);
          PH_DONE:            ;
          default:            emit_final(ST_UNTERM);
        endcase
        clear_line();
      end
    endfunction

    task report(string what);
      errors++;
      $display("ERROR at %0t: %s", $time, what);
    endtask

    task check_result(logic [7:0] ob, logic fin, logic [2:0] st, logic [15:0] len);
      result_t exp_r;
      if (decoded_q.size() == 0) begin
        report($sformatf("unexpected result byte=%h final=%b status=%0d length=%0d",
                         ob, fin, st, len));
        return;
      end
      exp_r = decoded_q.pop_front();
      if (fin !== exp_r.final_res)
        report($sformatf("final %b, expected %b", fin, exp_r.final_res));
      if (ob !== exp_r.out_byte)
        report($sformatf("byte %h, expected %h", ob, exp_r.out_byte));
      if (st !== exp_r.status)
        report($sformatf("status %0d, expected %0d", st, exp_r.status));
      if (len !== exp_r.length)
        report($sformatf("length %0d, expected %0d", len, exp_r.length));
    endtask

    task report_leftover();
      if (decoded_q.size() != 0)
        report($sformatf("%0d expected results never came", decoded_q.size()));
    endtask
  endclass

endpackage

/* tb/sv/testbench.sv */
// Top-level testbench of the JSON string field extractor core
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import jsfx_pkg::*;
  import jsfx_tb_pkg::*;

  typedef enum int unsigned {
    LINE_NOISE,
    LINE_NEAR_MISS,
    LINE_BAD_COLON,
    LINE_BAD_QUOTE,
    LINE_OPEN_VALUE,
    LINE_KEY_ONLY,
    LINE_GOOD
  } line_kind_e;

  typedef enum int unsigned {
    KEY_PRINTABLE,
    KEY_HIGH,
    KEY_WITH_NUL
  } key_style_e;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [63:0] cfg_data;

  bit          tx_burst;
  bit          rx_burst;
  int unsigned hold_cycles;
  logic [7:0]  line_bytes [$];
  logic [7:0]  key_chars [KEY_BYTES];
  int unsigned key_used;

  field_scoreboard sb = new();

  jsfx_in_if  req ();
  jsfx_out_if rsp ();

  json_string_field_extractor_core uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .req_i      (req),
    .rsp_o      (rsp),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (req.valid && req.ready) sb.take_request(req.in_byte, req.line_end);
      if (rsp.valid && rsp.ready)
        sb.check_result(rsp.out_byte, rsp.final_res, rsp.status, rsp.length);
    end
  end

  initial begin
    int unsigned stall;
    rsp.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_cycles > 0) begin
        rsp.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      stall = rx_burst ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
    end
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  task automatic send_req(logic [7:0] b, logic last);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid    <= 1'b1;
    req.in_byte  <= b;
    req.line_end <= last;
    do @(posedge clk); while (!req.ready);
  endtask

  task automatic send_line();
    foreach (line_bytes[i]) send_req(line_bytes[i], i == line_bytes.size() - 1);
  endtask

  task automatic send_text(string head, bit with_nul, string tail);
    line_bytes.delete();
    for (int i = 0; i < head.len(); i++) line_bytes.push_back(head[i]);
    if (with_nul) line_bytes.push_back(CH_NUL);
    for (int i = 0; i < tail.len(); i++) line_bytes.push_back(tail[i]);
    send_line();
  endtask

  task automatic wait_idle();
    req.valid <= 1'b0;
    @(posedge clk);
    while (sb.decoded_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic configure(logic [4:0] klen, logic [15:0] capv, key_style_e style);
    logic [63:0] lo;
    logic [63:0] hi;
    foreach (key_chars[i]) begin
      if (style == KEY_HIGH) key_chars[i] = 8'($urandom_range(128, 255));
      else key_chars[i] = 8'($urandom_range(33, 126));
    end
    key_used = (klen > KEY_MAX_DEF) ? KEY_MAX_DEF : klen;
    if (style == KEY_WITH_NUL && key_used > 0)
      key_chars[$urandom_range(0, key_used - 1)] = CH_NUL;
    for (int i = 0; i < 8; i++) begin
      lo[8*i +: 8] = key_chars[i];
      hi[8*i +: 8] = key_chars[i+8];
    end
    write_reg(REG_KEY_LO, lo);
    write_reg(REG_KEY_HI, hi);
    write_reg(REG_KEY_LEN, 64'(klen));
    write_reg(REG_CAP, 64'(capv));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] noise_byte();
    if ($urandom_range(0, 29) == 0) return CH_NUL;
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic logic [7:0] value_char();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE || b == CH_BSL);
    return b;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] d);
    if (d < 10) return "0" + d;
    if ($urandom_range(0, 1) == 1) return "a" + d - 10;
    return "A" + d - 10;
  endfunction

  function automatic logic [15:0] draw_code();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 3) return 16'($urandom_range(0, 16'h007F));
    if (r < 6) return 16'($urandom_range(16'h0080, 16'h07FF));
    if (r == 9) return 16'($urandom_range(SURR_LO, SURR_HI));
    if (r == 6) return 16'($urandom_range(16'h0800, 16'hD7FF));
    return 16'($urandom_range(16'hE000, 16'hFFFF));
  endfunction

  function automatic logic [7:0] escape_char(int unsigned idx);
    case (idx)
      0: return CH_QUOTE;
      1: return CH_BSL;
      2: return CH_SLASH;
      3: return CH_ESC_B;
      4: return CH_ESC_F;
      5: return CH_ESC_N;
      6: return CH_ESC_R;
      default: return CH_ESC_T;
    endcase
  endfunction

  task automatic push_code(logic [15:0] cp);
    line_bytes.push_back(CH_BSL);
    line_bytes.push_back(CH_U);
    for (int i = 3; i >= 0; i--) line_bytes.push_back(hex_char(cp[4*i +: 4]));
  endtask

  task automatic push_blanks();
    repeat ($urandom_range(0, 2))
      line_bytes.push_back(($urandom_range(0, 1) == 1) ? CH_SPACE : CH_TAB);
  endtask

  task automatic push_key();
    line_bytes.push_back(CH_QUOTE);
    for (int i = 0; i < key_used; i++) line_bytes.push_back(key_chars[i]);
    line_bytes.push_back(CH_QUOTE);
  endtask

  task automatic push_value_piece();
    int unsigned sel;
    int unsigned bad_at;
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      line_bytes.push_back(value_char());
    end else if (sel < 65) begin
      line_bytes.push_back(CH_BSL);
      line_bytes.push_back(escape_char($urandom_range(0, 7)));
    end else if (sel < 92) begin
      push_code(draw_code());
    end else if (sel < 96) begin
      line_bytes.push_back(CH_BSL);
      line_bytes.push_back(noise_byte());
    end else if (sel < 98) begin
      line_bytes.push_back(CH_BSL);
      line_bytes.push_back(CH_U);
      bad_at = $urandom_range(0, 3);
      for (int i = 0; i < bad_at; i++) line_bytes.push_back(hex_char(4'($urandom_range(0, 15))));
      line_bytes.push_back(noise_byte());
    end else begin
      line_bytes.push_back(CH_NUL);
    end
  endtask

  task automatic build_random_line();
    int unsigned r;
    line_kind_e kind;
    line_bytes.delete();
    r = $urandom_range(0, 11);
    kind = (r > LINE_GOOD) ? LINE_GOOD : line_kind_e'(r);
    repeat ($urandom_range(0, 2)) line_bytes.push_back(noise_byte());
    if (kind == LINE_NOISE) begin
      repeat ($urandom_range(1, 6)) line_bytes.push_back(noise_byte());
      return;
    end
    if (kind == LINE_NEAR_MISS) begin
      line_bytes.push_back(CH_QUOTE);
      for (int i = 0; i < key_used / 2; i++) line_bytes.push_back(key_chars[i]);
    end
    push_key();
    if (kind == LINE_KEY_ONLY) begin
      push_blanks();
      return;
    end
    push_blanks();
    line_bytes.push_back((kind == LINE_BAD_COLON) ? noise_byte() : CH_COLON);
    push_blanks();
    line_bytes.push_back((kind == LINE_BAD_QUOTE) ? noise_byte() : CH_QUOTE);
    repeat ($urandom_range(0, 5)) push_value_piece();
    if (kind != LINE_OPEN_VALUE) line_bytes.push_back(CH_QUOTE);
    repeat ($urandom_range(0, 2)) line_bytes.push_back(noise_byte());
  endtask

  task automatic build_long_line();
    line_bytes.delete();
    push_key();
    line_bytes.push_back(CH_COLON);
    line_bytes.push_back(CH_QUOTE);
    repeat (3) push_code(16'($urandom_range(16'h0800, 16'hD7FF)));
    repeat (2) line_bytes.push_back(value_char());
    line_bytes.push_back(CH_QUOTE);
  endtask

  task automatic run_phase(int unsigned budget);
    int unsigned sent;
    sent = 0;
    while (sent < budget) begin
      tx_burst = ($urandom_range(0, 4) == 0);
      rx_burst = ($urandom_range(0, 4) == 0);
      build_random_line();
      send_line();
      sent += line_bytes.size();
    end
    wait_idle();
  endtask

  initial begin
    req.valid    <= 1'b0;
    req.in_byte  <= '0;
    req.line_end <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_idx      <= REG_KEY_LO;
    cfg_data     <= '0;
    rst_n        <= 1'b0;
    tx_burst     = 1'b0;
    rx_burst     = 1'b0;
    hold_cycles  = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_text("\"\":\"A\\\"\\\\\\/\\b\\f\\n\\r\\t\"", 1'b0, "");
    send_text("\"\":\"\\u007f\\u00E9\\uFFFF\"", 1'b0, "");
    send_text("\"\":\"\\uDBFFx\"", 1'b0, "");
    send_text("\"\":\"\\q\"", 1'b0, "");
    send_text("\"\":\"\\u1G00\"", 1'b0, "");
    send_text("\"\": \t\"ab", 1'b0, "");
    send_text("\"\";", 1'b0, "");
    send_text("\"\" :x", 1'b0, "");
    send_text("ab", 1'b0, "");
    send_text("a", 1'b1, "b");
    send_text("\"\":\"a", 1'b1, "\"");
    send_text("\"\":\"\\u1", 1'b1, "");
    send_text("\"\":\"\\", 1'b1, "");
    send_text("\"\"", 1'b1, ":");
    send_text("\"\":\"\\", 1'b0, "");
    wait_idle();

    configure(5'd3, 16'd12, KEY_PRINTABLE);
    run_phase(10);
    configure(5'd31, 16'd1, KEY_HIGH);
    run_phase(15);
    configure(5'd4, 16'd40, KEY_WITH_NUL);
    run_phase(10);

    configure(5'd8, CAP_RST, KEY_PRINTABLE);
    tx_burst    = 1'b1;
    hold_cycles = 200;
    build_long_line();
    send_line();

    req.valid <= 1'b0;
    @(posedge clk);
    for (int n = 0; n < 5000 && sb.decoded_q.size() != 0; n++) @(posedge clk);
    repeat (10) @(posedge clk);
    sb.report_leftover();
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/jsfx_pkg.sv
hw/rtl/jsfx_if.sv
hw/rtl/jsfx_cell.sv
hw/rtl/jsfx_window.sv
hw/rtl/jsfx_fifo.sv
hw/rtl/json_string_field_extractor_core.sv
tb/sv/jsfx_tb_pkg.sv
tb/sv/testbench.sv
